// ===== sv/wke_pkg.sv =====
`default_nettype none
package wke_pkg;

  // fixed field widths
  localparam int MAG_W     = 32;   // |origin - neighbour| always fits 32 bits
  localparam int SQ_W      = 64;
  localparam int R2_W      = 66;
  localparam int ROOT_W    = 33;
  localparam int CFG_W     = 32;
  localparam int WEIGHT_W  = 31;
  localparam int GRAD_W    = 32;
  localparam int W_W       = 39;   // weight before saturation
  localparam int P_W       = 40;   // gradient magnitude factor
  localparam int P_LO_W    = 20;   // split of P for the final multiply
  localparam int M_W       = 41;   // per-axis gradient magnitude
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_H = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W_FAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_G_FAC = 2'd2;

  // saturation limits
  localparam logic [M_W-1:0] POS_LIM = 41'h0_7FFF_FFFF;
  localparam logic [M_W-1:0] NEG_LIM = 41'h0_8000_0000;
  localparam logic [W_W-1:0] W_LIM   = 39'h00_7FFF_FFFF;

  // pair data travelling beside the square root
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } pair_t;

  // flags travelling beside the kernel polynomial
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic       outside;
  } flags_t;

  // kernel results waiting for the direction quotients
  typedef struct packed {
    logic [W_W-1:0] w;
    logic [P_W-1:0] p;
    flags_t         flags;
  } kern_t;

endpackage
`default_nettype wire

// ===== sv/wke_sqrt.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module wke_sqrt #(
  parameter int TAG_W = 99
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_vld,
  input  wire logic [wke_pkg::R2_W-1:0]   in_r2,
  input  wire logic [TAG_W-1:0]           in_tag,
  output logic                            out_vld,
  output logic [wke_pkg::ROOT_W-1:0]      out_root,
  output logic [TAG_W-1:0]                out_tag
);

  localparam int RW = wke_pkg::R2_W + 2;
  localparam int NS = wke_pkg::ROOT_W;

  logic [RW-1:0]    rem_r  [NS];
  logic [NS-1:0]    root_r [NS];
  logic [TAG_W-1:0] tag_r  [NS];
  logic             vld_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [RW-1:0]    rem_prev;
    logic [NS-1:0]    root_prev;
    logic [TAG_W-1:0] tag_prev;
    logic             vld_prev;
    logic [RW-1:0]    trial;
    logic             take;
    logic [RW-1:0]    rem_nxt;
    logic [NS-1:0]    root_nxt;

    if (s == 0) begin : g_first
      assign rem_prev  = RW'(in_r2);
      assign root_prev = '0;
      assign tag_prev  = in_tag;
      assign vld_prev  = in_vld;
    end else begin : g_next
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
      assign tag_prev  = tag_r[s-1];
      assign vld_prev  = vld_r[s-1];
    end

    // (root + 2^B)^2 - root^2 against what is left
    assign trial    = (RW'(root_prev) << (B + 1)) | (RW'(1) << (2 * B));
    assign take     = (trial <= rem_prev);
    assign rem_nxt  = take ? (rem_prev - trial) : rem_prev;
    assign root_nxt = take ? (root_prev | (NS'(1) << B)) : root_prev;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      tag_r[s]  <= tag_prev;
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_root = root_r[NS-1];
  assign out_tag  = tag_r[NS-1];

endmodule
`default_nettype wire

// ===== sv/wke_div.sv =====
`default_nettype none
// Pipelined restoring divider: (num << FRAC_BITS) / den, quotient at most 1.0 when num <= den.
module wke_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic [wke_pkg::MAG_W-1:0]     in_num,
  input  wire logic [wke_pkg::ROOT_W-1:0]    in_den,
  output logic [FRAC_BITS:0]                 out_quo
);

  localparam int NW = wke_pkg::ROOT_W + FRAC_BITS;
  localparam int QB = FRAC_BITS + 1;
  localparam int DW = wke_pkg::ROOT_W;

  logic [NW-1:0] rem_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [NW-1:0] rem_prev;
    logic [DW-1:0] den_prev;
    logic [QB-1:0] quo_prev;
    logic [NW-1:0] trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_prev = NW'(in_num) << FRAC_BITS;
      assign den_prev = in_den;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[s-1];
      assign den_prev = den_r[s-1];
      assign quo_prev = quo_r[s-1];
    end

    assign trial = NW'(den_prev) << K;
    assign take  = (trial <= rem_prev);

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? (rem_prev - trial) : rem_prev;
      quo_r[s] <= take ? (quo_prev | (QB'(1) << K)) : quo_prev;
      den_r[s] <= den_prev;
    end
  end

  assign out_quo = quo_r[QB-1];

endmodule
`default_nettype wire

// ===== sv/wke_poly.sv =====
`default_nettype none
// Wendland polynomial: weight and gradient magnitude from q, four stages.
module wke_poly #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [FRAC_BITS+1:0]          in_q,
  input  wire wke_pkg::flags_t               in_flags,
  input  wire logic [wke_pkg::CFG_W-1:0]     weight_factor,
  input  wire logic [wke_pkg::CFG_W-1:0]     gradient_factor,
  output logic                               out_vld,
  output logic [wke_pkg::W_W-1:0]            out_w,
  output logic [wke_pkg::P_W-1:0]            out_p,
  output wke_pkg::flags_t                    out_flags
);

  localparam int Q_W  = FRAC_BITS + 2;
  localparam int T2_W = FRAC_BITS + 3;
  localparam int T3_W = FRAC_BITS + 4;
  localparam int T4_W = FRAC_BITS + 5;
  localparam int S_W  = FRAC_BITS + 3;
  localparam int QT_W = FRAC_BITS + 5;
  localparam int W1_W = FRAC_BITS + 7;
  localparam int G_W  = FRAC_BITS + 8;
  localparam int CW   = wke_pkg::CFG_W;
  localparam int WW   = wke_pkg::W_W;
  localparam int PW   = wke_pkg::P_W;
  localparam logic [Q_W-1:0] TWO = Q_W'(2) << FRAC_BITS;
  localparam logic [S_W-1:0] ONE = S_W'(1) << FRAC_BITS;

  // stage 1: t = 2 - q, t^2
  logic                  p1_vld_r;
  logic [Q_W-1:0]        p1_t_r, p1_q_r;
  logic [T2_W-1:0]       p1_t2_r;
  wke_pkg::flags_t       p1_flags_r;
  logic [Q_W-1:0]        t_nxt;
  logic [2*Q_W-1:0]      tt;

  assign t_nxt = TWO - in_q;
  assign tt    = t_nxt * t_nxt;

  always_ff @(posedge clk) begin
    p1_t_r     <= t_nxt;
    p1_q_r     <= in_q;
    p1_t2_r    <= T2_W'(tt >> FRAC_BITS);
    p1_flags_r <= in_flags;
  end

  // stage 2: t^4, t^3, 2q+1
  logic                  p2_vld_r;
  logic [T4_W-1:0]       p2_t4_r;
  logic [T3_W-1:0]       p2_t3_r;
  logic [Q_W-1:0]        p2_q_r;
  logic [S_W-1:0]        p2_s_r;
  wke_pkg::flags_t       p2_flags_r;
  logic [2*T2_W-1:0]     t2t2;
  logic [T2_W+Q_W-1:0]   t2t;

  assign t2t2 = p1_t2_r * p1_t2_r;
  assign t2t  = p1_t2_r * p1_t_r;

  always_ff @(posedge clk) begin
    p2_t4_r    <= T4_W'(t2t2 >> FRAC_BITS);
    p2_t3_r    <= T3_W'(t2t >> FRAC_BITS);
    p2_q_r     <= p1_q_r;
    p2_s_r     <= (S_W'(p1_q_r) << 1) + ONE;
    p2_flags_r <= p1_flags_r;
  end

  // stage 3: t^4 (2q+1), 10 q t^3
  logic                  p3_vld_r;
  logic [W1_W-1:0]       p3_w1_r;
  logic [G_W-1:0]        p3_g_r;
  wke_pkg::flags_t       p3_flags_r;
  logic [T4_W+S_W-1:0]   w1_full;
  logic [Q_W+T3_W-1:0]   qt_full;
  logic [QT_W-1:0]       qt;

  assign w1_full = p2_t4_r * p2_s_r;
  assign qt_full = p2_q_r * p2_t3_r;
  assign qt      = QT_W'(qt_full >> FRAC_BITS);

  always_ff @(posedge clk) begin
    p3_w1_r    <= W1_W'(w1_full >> FRAC_BITS);
    p3_g_r     <= (G_W'(qt) << 3) + (G_W'(qt) << 1);
    p3_flags_r <= p2_flags_r;
  end

  // stage 4: scale by the normalisation factors
  logic                  p4_vld_r;
  logic [WW-1:0]         p4_w_r;
  logic [PW-1:0]         p4_p_r;
  wke_pkg::flags_t       p4_flags_r;
  logic [W1_W+CW-1:0]    w_full;
  logic [G_W+CW-1:0]     p_full;

  assign w_full = p3_w1_r * weight_factor;
  assign p_full = p3_g_r * gradient_factor;

  always_ff @(posedge clk) begin
    p4_w_r     <= WW'(w_full >> FRAC_BITS);
    p4_p_r     <= PW'(p_full >> FRAC_BITS);
    p4_flags_r <= p3_flags_r;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= in_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
  end

  assign out_vld   = p4_vld_r;
  assign out_w     = p4_w_r;
  assign out_p     = p4_p_r;
  assign out_flags = p4_flags_r;

endmodule
`default_nettype wire

// ===== sv/wendland_kernel_eval_core.sv =====
`default_nettype none
// Wendland C2 SPH kernel evaluator. One neighbour pair is taken with start in
// any cycle (busy stays low) and its word appears on the out_ ports, marked by
// out_valid for one cycle. The receiver cannot stall, so every pair comes out.
// The pipeline depth is set by the 33-stage square root and the FRAC_BITS + 1
// stage direction dividers; three input stages and two output multiply stages
// complete it. Registers are written through cfg_ with cfg_ready always high
// and must only change while no pair is in flight.
module wendland_kernel_eval_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [31:0]                in_origin_x,
  input  wire logic signed [31:0]                in_origin_y,
  input  wire logic signed [31:0]                in_origin_z,
  input  wire logic signed [31:0]                in_neighbour_x,
  input  wire logic signed [31:0]                in_neighbour_y,
  input  wire logic signed [31:0]                in_neighbour_z,
  output logic                                   out_valid,
  output logic [30:0]                            out_weight,
  output logic signed [31:0]                     out_grad_x,
  output logic signed [31:0]                     out_grad_y,
  output logic signed [31:0]                     out_grad_z,
  output logic                                   out_outside_radius,
  output logic                                   out_zero_distance,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wke_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wke_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW     = wke_pkg::CFG_W;
  localparam int MW     = wke_pkg::MAG_W;
  localparam int SW     = wke_pkg::SQ_W;
  localparam int R2W    = wke_pkg::R2_W;
  localparam int RTW    = wke_pkg::ROOT_W;
  localparam int PW     = wke_pkg::P_W;
  localparam int PLW    = wke_pkg::P_LO_W;
  localparam int PHW    = PW - PLW;
  localparam int MXW    = wke_pkg::M_W;
  localparam int GW     = wke_pkg::GRAD_W;
  localparam int WTW    = wke_pkg::WEIGHT_W;
  localparam int Q_W    = FRAC_BITS + 2;
  localparam int U_W    = FRAC_BITS + 1;
  localparam int PR_W   = 65;
  localparam int MF_W   = U_W + PW;
  localparam int DLY    = FRAC_BITS - 5;
  localparam int TAG_W  = $bits(wke_pkg::pair_t);
  localparam logic [PR_W-1:0] TWO_Q = PR_W'(2) << FRAC_BITS;

  // configuration registers
  logic [CW-1:0] inv_r, wf_r, gf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= CW'(1) << FRAC_BITS;
      wf_r  <= CW'(7) << (FRAC_BITS - 6);
      gf_r  <= CW'(7) << (FRAC_BITS - 6);
    end else if (cfg_valid) begin
      case (cfg_index)
        wke_pkg::CFG_INV_H: inv_r <= cfg_data;
        wke_pkg::CFG_W_FAC: wf_r  <= cfg_data;
        wke_pkg::CFG_G_FAC: gf_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // stage A: separation and its magnitude per axis
  logic signed [MW:0]  dx, dy, dz;
  wke_pkg::pair_t      a_pair_nxt, a_pair_r;
  logic                a_vld_r;

  assign dx = (MW+1)'(in_origin_x) - (MW+1)'(in_neighbour_x);
  assign dy = (MW+1)'(in_origin_y) - (MW+1)'(in_neighbour_y);
  assign dz = (MW+1)'(in_origin_z) - (MW+1)'(in_neighbour_z);

  always_comb begin
    a_pair_nxt.neg    = {dz[MW], dy[MW], dx[MW]};
    a_pair_nxt.mag[0] = dx[MW] ? MW'(-dx) : MW'(dx);
    a_pair_nxt.mag[1] = dy[MW] ? MW'(-dy) : MW'(dy);
    a_pair_nxt.mag[2] = dz[MW] ? MW'(-dz) : MW'(dz);
  end

  always_ff @(posedge clk) begin
    a_pair_r <= a_pair_nxt;
  end

  // stage B: squares
  logic [SW-1:0]       b_sq_r [3];
  wke_pkg::pair_t      b_pair_r;
  logic                b_vld_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      b_sq_r[j] <= a_pair_r.mag[j] * a_pair_r.mag[j];
    end
    b_pair_r <= a_pair_r;
  end

  // stage C: squared length
  logic [R2W-1:0]      c_r2_r;
  wke_pkg::pair_t      c_pair_r;
  logic                c_vld_r;

  always_ff @(posedge clk) begin
    c_r2_r   <= R2W'(b_sq_r[0]) + R2W'(b_sq_r[1]) + R2W'(b_sq_r[2]);
    c_pair_r <= b_pair_r;
  end

  // square root
  logic                s_vld;
  logic [RTW-1:0]      s_root;
  logic [TAG_W-1:0]    s_tag;
  wke_pkg::pair_t      s_pair;

  wke_sqrt #(
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_r2    (c_r2_r),
    .in_tag   (c_pair_r),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_tag  (s_tag)
  );

  assign s_pair = wke_pkg::pair_t'(s_tag);

  // direction quotients |d_j| / r, one divider per axis
  logic [U_W-1:0] u_quo [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    wke_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .in_num  (s_pair.mag[j]),
      .in_den  (s_root),
      .out_quo (u_quo[j])
    );
  end

  // stage Q1: low part of r * inv
  logic [2*CW-1:0]     q1_prod_r;
  logic                q1_top_r, q1_zero_r, q1_vld_r;
  logic [2:0]          q1_neg_r;

  always_ff @(posedge clk) begin
    q1_prod_r <= s_root[CW-1:0] * inv_r;
    q1_top_r  <= s_root[RTW-1];
    q1_zero_r <= (s_root == '0);
    q1_neg_r  <= s_pair.neg;
  end

  // stage Q2: q and the support test
  logic [PR_W-1:0]     prod_full, q_full;
  logic [Q_W-1:0]      q2_q_r;
  wke_pkg::flags_t     q2_flags_r;
  logic                q2_vld_r;

  assign prod_full = PR_W'(q1_prod_r)
                   + (q1_top_r ? (PR_W'(inv_r) << CW) : '0);
  assign q_full    = prod_full >> FRAC_BITS;

  always_ff @(posedge clk) begin
    q2_q_r             <= Q_W'(q_full);
    q2_flags_r.neg     <= q1_neg_r;
    q2_flags_r.zero    <= q1_zero_r;
    q2_flags_r.outside <= (q_full > TWO_Q);
  end

  // kernel polynomial
  logic                k_vld;
  logic [wke_pkg::W_W-1:0] k_w;
  logic [PW-1:0]       k_p;
  wke_pkg::flags_t     k_flags;

  wke_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (q2_vld_r),
    .in_q            (q2_q_r),
    .in_flags        (q2_flags_r),
    .weight_factor   (wf_r),
    .gradient_factor (gf_r),
    .out_vld         (k_vld),
    .out_w           (k_w),
    .out_p           (k_p),
    .out_flags       (k_flags)
  );

  // delay kernel words to meet the divider outputs
  wke_pkg::kern_t      dl_r   [DLY];
  logic                dl_vld_r [DLY];

  for (genvar s = 0; s < DLY; s++) begin : g_dly
    wke_pkg::kern_t dl_prev;
    logic           dl_vld_prev;

    if (s == 0) begin : g_first
      assign dl_prev.w     = k_w;
      assign dl_prev.p     = k_p;
      assign dl_prev.flags = k_flags;
      assign dl_vld_prev   = k_vld;
    end else begin : g_next
      assign dl_prev     = dl_r[s-1];
      assign dl_vld_prev = dl_vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_vld_r[s] <= 1'b0;
      end else begin
        dl_vld_r[s] <= dl_vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      dl_r[s] <= dl_prev;
    end
  end

  // stage M1: u_j * p in two halves
  wke_pkg::kern_t      k_dl;
  logic [U_W+PLW-1:0]  m1_lo_r [3];
  logic [U_W+PHW-1:0]  m1_hi_r [3];
  logic [wke_pkg::W_W-1:0] m1_w_r;
  wke_pkg::flags_t     m1_flags_r;
  logic                m1_vld_r;

  assign k_dl = dl_r[DLY-1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      m1_lo_r[j] <= u_quo[j] * k_dl.p[PLW-1:0];
      m1_hi_r[j] <= u_quo[j] * k_dl.p[PW-1:PLW];
    end
    m1_w_r     <= k_dl.w;
    m1_flags_r <= k_dl.flags;
  end

  // stage M2: combine, saturate, apply special cases
  logic [MF_W-1:0]     m_full [3];
  logic [MXW-1:0]      m_mag  [3];
  logic [GW-1:0]       grad_nxt [3];
  logic [WTW-1:0]      weight_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      m_full[j] = (MF_W'(m1_hi_r[j]) << PLW) + MF_W'(m1_lo_r[j]);
      m_mag[j]  = MXW'(m_full[j] >> FRAC_BITS);
      if (m1_flags_r.outside || m1_flags_r.zero) begin
        grad_nxt[j] = '0;
      end else if (m1_flags_r.neg[j]) begin
        grad_nxt[j] = (m_mag[j] > wke_pkg::POS_LIM) ? GW'(wke_pkg::POS_LIM)
                                                    : GW'(m_mag[j]);
      end else begin
        grad_nxt[j] = (m_mag[j] > wke_pkg::NEG_LIM) ? -GW'(wke_pkg::NEG_LIM)
                                                    : -GW'(m_mag[j]);
      end
    end
    if (m1_flags_r.outside) begin
      weight_nxt = '0;
    end else if (m1_w_r > wke_pkg::W_LIM) begin
      weight_nxt = '1;
    end else begin
      weight_nxt = WTW'(m1_w_r);
    end
  end

  logic                out_valid_r;
  logic [WTW-1:0]      out_weight_r;
  logic [GW-1:0]       out_grad_r [3];
  logic                out_outside_r, out_zero_r;

  always_ff @(posedge clk) begin
    out_weight_r  <= weight_nxt;
    for (int j = 0; j < 3; j++) begin
      out_grad_r[j] <= grad_nxt[j];
    end
    out_outside_r <= m1_flags_r.outside;
    out_zero_r    <= m1_flags_r.zero & ~m1_flags_r.outside;
  end

  // valid chain of the front and back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      q1_vld_r    <= 1'b0;
      q2_vld_r    <= 1'b0;
      m1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= start & ~busy;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      q1_vld_r    <= s_vld;
      q2_vld_r    <= q1_vld_r;
      m1_vld_r    <= dl_vld_r[DLY-1];
      out_valid_r <= m1_vld_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_weight         = out_weight_r;
  assign out_grad_x         = out_grad_r[0];
  assign out_grad_y         = out_grad_r[1];
  assign out_grad_z         = out_grad_r[2];
  assign out_outside_radius = out_outside_r;
  assign out_zero_distance  = out_zero_r;

`ifndef SYNTHESIS
  // beyond the support every value is zero
  a_outside_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside_radius |->
      out_weight == '0 && out_grad_x == '0 && out_grad_y == '0 &&
      out_grad_z == '0 && !out_zero_distance)
    else $error("outside support with non-zero result");

  // coincident particles give no gradient
  a_zero_grad : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_distance |->
      out_grad_x == '0 && out_grad_y == '0 && out_grad_z == '0)
    else $error("gradient at zero distance");

  // reset empties the pipeline
  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
`endif

endmodule
`default_nettype wire

// ===== dv/wendland_kernel_eval_core_test.sv =====
`timescale 1ns / 1ps
module wendland_kernel_eval_core_test;

  localparam int FRAC = 16;
  localparam logic [wke_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // unmapped index, ignored
  localparam int DRAIN_CYCLES = FRAC + 45;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [127:0] ONE = 128'd1 << FRAC;

  typedef struct {
    logic [30:0] weight;
    logic [31:0] gx, gy, gz;
    logic        outside;
    logic        zero;
  } kernel_word_t;

  logic clk, rst_n, start, busy;
  logic signed [31:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [31:0] in_neighbour_x, in_neighbour_y, in_neighbour_z;
  logic out_valid, out_outside_radius, out_zero_distance;
  logic [30:0] out_weight;
  logic signed [31:0] out_grad_x, out_grad_y, out_grad_z;
  logic cfg_valid, cfg_ready;
  logic [wke_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wke_pkg::CFG_W-1:0] cfg_data;

  // local copy of the register file
  logic [31:0] inv_h_reg, w_fac_reg, g_fac_reg;
  kernel_word_t pending_words[$];
  int errors;
  int cycles;
  bit burst;

  wendland_kernel_eval_core dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // kernel value and gradient for one pair
  function automatic kernel_word_t kernel_predict(
      logic signed [31:0] ox, oy, oz, nx, ny, nz);
    logic signed [32:0] d[3];
    logic [127:0] mag[3], r2, r, c, prod, q, t, t2, t3, t4, w, g, p, u, m;
    kernel_word_t k;
    d[0] = $signed({ox[31], ox}) - $signed({nx[31], nx});
    d[1] = $signed({oy[31], oy}) - $signed({ny[31], ny});
    d[2] = $signed({oz[31], oz}) - $signed({nz[31], nz});
    k = '{default: '0};
    r2 = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = d[j] < 0 ? 128'(-d[j]) : 128'(d[j]);
      r2 += mag[j] * mag[j];
    end
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= r2) r = c;
    end
    prod = r * inv_h_reg;
    q = prod >> FRAC;
    if (q > 2 * ONE) begin
      k.outside = 1;
      return k;
    end
    t = 2 * ONE - q;
    t2 = (t * t) >> FRAC;
    t4 = (t2 * t2) >> FRAC;
    t3 = (t2 * t) >> FRAC;
    w = (t4 * (2 * q + ONE)) >> FRAC;
    w = (w * w_fac_reg) >> FRAC;
    k.weight = w > 128'h7FFF_FFFF ? 31'h7FFF_FFFF : w[30:0];
    if (r == 0) begin
      k.zero = 1;
      return k;
    end
    g = 10 * ((q * t3) >> FRAC);
    p = (g * g_fac_reg) >> FRAC;
    for (int j = 0; j < 3; j++) begin
      u = (mag[j] << FRAC) / r;
      m = (u * p) >> FRAC;
      // gradient points against the separation
      if (d[j] < 0) m = m > 128'h7FFF_FFFF ? 128'h7FFF_FFFF : m;
      else m = -(m > 128'h8000_0000 ? 128'h8000_0000 : m);
      if (j == 0) k.gx = m[31:0];
      else if (j == 1) k.gy = m[31:0];
      else k.gz = m[31:0];
    end
    return k;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    kernel_word_t k;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", 32'(out_weight), 32'h0);
      end else begin
        k = pending_words.pop_front();
        check_field("weight", 32'(out_weight), 32'(k.weight));
        check_field("grad_x", out_grad_x, k.gx);
        check_field("grad_y", out_grad_y, k.gy);
        check_field("grad_z", out_grad_z, k.gz);
        check_field("outside_radius", 32'(out_outside_radius), 32'(k.outside));
        check_field("zero_distance", 32'(out_zero_distance), 32'(k.zero));
      end
    end
  end

  // send one pair after a gap, holding start until taken
  task automatic send_pair(int gap, logic signed [31:0] ox, oy, oz, nx, ny, nz);
    repeat (gap) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_origin_z <= oz;
    in_neighbour_x <= nx;
    in_neighbour_y <= ny;
    in_neighbour_z <= nz;
    do @(posedge clk); while (busy);
    pending_words.push_back(kernel_predict(ox, oy, oz, nx, ny, nz));
  endtask

  task automatic send_offset(int gap, logic signed [31:0] ox, oy, oz, dx, dy, dz);
    send_pair(gap, ox, oy, oz, ox - dx, oy - dy, oz - dz);
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [wke_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wke_pkg::CFG_INV_H: inv_h_reg = value;
      wke_pkg::CFG_W_FAC: w_fac_reg = value;
      wke_pkg::CFG_G_FAC: g_fac_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  // random pair: mostly near neighbours, some coincident or arbitrary
  task automatic send_random(int span);
    logic signed [31:0] ox, oy, oz;
    int sel;
    ox = $urandom;
    oy = $urandom;
    oz = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 7)
      send_offset(draw_gap(), ox, oy, oz,
                  $signed($urandom_range(0, 2 * span)) - span,
                  $signed($urandom_range(0, 2 * span)) - span,
                  $signed($urandom_range(0, 2 * span)) - span);
    else if (sel == 7)
      send_offset(draw_gap(), ox, oy, oz, 0, 0, 0);
    else
      send_pair(draw_gap(), ox, oy, oz, $urandom, $urandom, $urandom);
  endtask

  // reset values, support edge, coincidence, coordinate extremes
  task automatic test_directed_defaults();
    send_offset(0, 0, 0, 0, 0, 0, 0);
    send_offset(0, 32'h7FFF_FFFF, 32'h8000_0000, 5, 0, 0, 0);
    send_offset(1, 0, 0, 0, 32'sd131072, 0, 0);
    send_offset(0, 0, 0, 0, 32'sd131073, 0, 0);
    send_offset(0, 0, 0, 0, -32'sd131072, 0, 0);
    send_offset(2, 100, 200, 300, 32'sd65536, -32'sd40000, 32'sd1000);
    send_offset(0, -7, 9, 0, -32'sd30000, 32'sd30000, -32'sd30000);
    send_offset(0, 0, 0, 0, 1, 0, 0);
    send_offset(0, 0, 0, 0, 0, -1, 0);
    send_offset(3, 0, 0, 0, 0, 0, 32'sd90000);
    send_pair(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(1, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000);
    drain();
  endtask

  // register extremes, zero inverse length and the unmapped index
  task automatic test_register_extremes();
    write_reg(wke_pkg::CFG_INV_H, 32'hFFFF_FFFF);
    write_reg(wke_pkg::CFG_W_FAC, 32'hFFFF_FFFF);
    write_reg(wke_pkg::CFG_G_FAC, 32'hFFFF_FFFF);
    send_offset(0, 0, 0, 0, 0, 0, 0);
    send_offset(0, 0, 0, 0, 1, 0, 0);
    send_offset(0, 0, 0, 0, 1, 1, 1);
    send_offset(0, 0, 0, 0, 3, 0, 0);
    drain();
    write_reg(wke_pkg::CFG_INV_H, 1);
    write_reg(wke_pkg::CFG_W_FAC, 0);
    write_reg(wke_pkg::CFG_G_FAC, 0);
    send_offset(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(1, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
    drain();
    write_reg(wke_pkg::CFG_INV_H, 0);
    write_reg(wke_pkg::CFG_W_FAC, 32'h0010_0000);
    write_reg(wke_pkg::CFG_G_FAC, 32'h0100_0000);
    write_reg(CFG_NONE, 32'h0000_0001);
    send_pair(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0);
    send_offset(0, 0, 0, 0, 5, -5, 5);
    drain();
  endtask

  // random pairs across several register settings
  task automatic test_random_pairs();
    logic [31:0] inv;
    longint span_l;
    int span;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: inv = 32'h0001_0000;
        1: inv = 32'h0000_4000;
        2: inv = 32'h0010_0000;
        3: inv = $urandom_range(1, 32'h0040_0000);
        4: inv = 32'h0000_0100;
        default: inv = $urandom;
      endcase
      write_reg(wke_pkg::CFG_INV_H, inv);
      write_reg(wke_pkg::CFG_W_FAC,
                phase[0] ? $urandom : $urandom_range(0, 32'h0004_0000));
      write_reg(wke_pkg::CFG_G_FAC,
                phase[1] ? $urandom : $urandom_range(0, 32'h0004_0000));
      if (phase == 5) write_reg(CFG_NONE, $urandom);
      // offsets a little wider than the support
      span_l = (inv == 0) ? 64'h7FFF_FFFF
                          : longint'((64'd3 << (2 * FRAC)) / inv) + 1;
      if (span_l > 64'h3FFF_FFFF) span_l = 64'h3FFF_FFFF;
      span = int'(span_l);
      for (int i = 0; i < 80; i++) begin
        if (i % 20 == 0) burst = $urandom_range(0, 2) == 0;
        send_random(span);
      end
      burst = 0;
      drain();
    end
  endtask

  initial begin
    errors = 0;
    burst = 0;
    rst_n = 0;
    start = 0;
    in_origin_x = 0;
    in_origin_y = 0;
    in_origin_z = 0;
    in_neighbour_x = 0;
    in_neighbour_y = 0;
    in_neighbour_z = 0;
    cfg_valid = 0;
    cfg_index = wke_pkg::CFG_INV_H;
    cfg_data = 0;
    inv_h_reg = 32'd65536;
    w_fac_reg = 32'd7168;
    g_fac_reg = 32'd7168;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed_defaults();
    test_register_extremes();
    test_random_pairs();
    drain();
    if (errors == 0 && pending_words.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wke_pkg.sv
sv/wke_sqrt.sv
sv/wke_div.sv
sv/wke_poly.sv
sv/wendland_kernel_eval_core.sv
dv/wendland_kernel_eval_core_test.sv
